// ----- rtl/rbf_pkg.sv -----
package rbf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int PIX_W          = 8;
   localparam int NUM_CH         = 3;
   localparam int WIDTH_REG_W    = 11;
   localparam int HEIGHT_REG_W   = 13;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

   // sum of nine 8-bit values fits in 12 bits; x7282 >> 16 equals /9 for it
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic             frame_end;
   } rsp_type;

   typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_type;

   typedef pixel_type [2:0] column_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
   } line_entry_type;

   typedef struct packed {
      logic [NUM_CH-1:0][SUM_W-1:0] sum;
      logic                         frame_end;
   } sum_item_type;

   typedef struct packed {
      logic         valid;
      sum_item_type item;
   } sum_xfer_type;

endpackage

// ----- rtl/rbf_front.sv -----
module rbf_front #(
   parameter int MAX_WIDTH  = rbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbf_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rbf_pkg::req_type                   req_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbf_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [rbf_pkg::QCNT_W-1:0]         queue_level,
   output rbf_pkg::sum_xfer_type              push
);
   import rbf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [CW-1:0]           col_ff, col_in, last_col;
   logic [RW-1:0]           row_ff, row_in, last_row;
   logic                    accept, restart;
   logic [QCNT_W:0]         pending;

   logic                    a_valid_ff, a_emit_ff, a_last_ff;
   logic [CW-1:0]           a_addr_ff;
   pixel_type               a_pix_ff;
   line_entry_type          rd_ff;
   line_entry_type          line_mem [MAX_WIDTH];

   column_type              win_ff [2];
   column_type              cur_col;

   logic                    b_valid_ff;
   sum_item_type            b_item_ff, b_item_in;

   assign csr_ready = 1'b1;
   assign restart   = csr_valid && (csr_index == CSR_IMAGE_WIDTH ||
                                    csr_index == CSR_IMAGE_HEIGHT);

   assign pending   = {1'b0, queue_level} + (QCNT_W+1)'(a_valid_ff) +
                      (QCNT_W+1)'(b_valid_ff);
   assign req_ready = pending < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_ff <= csr_data[WIDTH_REG_W-1:0];
         end
         if (csr_index == CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_data[HEIGHT_REG_W-1:0];
         end
      end
   end

   always_comb begin
      priority if (width_ff < WIDTH_REG_W'(3)) begin
         last_col = CW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         last_col = CW'(MAX_WIDTH - 1);
      end else begin
         last_col = CW'(width_ff - WIDTH_REG_W'(1));
      end
      priority if (height_ff < HEIGHT_REG_W'(3)) begin
         last_row = RW'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         last_row = RW'(MAX_HEIGHT - 1);
      end else begin
         last_row = RW'(height_ff - HEIGHT_REG_W'(1));
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : RW'(row_ff + RW'(1));
         end else begin
            col_in = CW'(col_ff + CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff && a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_addr_ff <= col_ff;
         a_pix_ff  <= {req_data.blue_in, req_data.green_in, req_data.red_in};
         a_emit_ff <= (row_ff >= RW'(2)) && (col_ff >= CW'(2));
         a_last_ff <= (row_ff == last_row) && (col_ff == last_col);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (a_valid_ff) begin
         line_mem[a_addr_ff] <= '{top: rd_ff.mid, mid: a_pix_ff};
      end
   end

   always_comb begin
      cur_col[0] = rd_ff.top;
      cur_col[1] = rd_ff.mid;
      cur_col[2] = a_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         win_ff[1] <= win_ff[0];
         win_ff[0] <= cur_col;
      end
   end

   always_comb begin
      b_item_in.frame_end = a_last_ff;
      for (int k = 0; k < NUM_CH; k++) begin
         b_item_in.sum[k] =
            (SUM_W'(cur_col[0][k])   + SUM_W'(cur_col[1][k])   + SUM_W'(cur_col[2][k])) +
            (SUM_W'(win_ff[0][0][k]) + SUM_W'(win_ff[0][1][k]) + SUM_W'(win_ff[0][2][k])) +
            (SUM_W'(win_ff[1][0][k]) + SUM_W'(win_ff[1][1][k]) + SUM_W'(win_ff[1][2][k]));
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   assign push.valid = b_valid_ff;
   assign push.item  = b_item_ff;

endmodule

// ----- rtl/rbf_queue.sv -----
module rbf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  rbf_pkg::sum_xfer_type       push,
   input  logic                        pop_ready,
   output rbf_pkg::sum_xfer_type       pop,
   output logic [rbf_pkg::QCNT_W-1:0]  level
);
   import rbf_pkg::*;

   sum_item_type        store_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                popped;

   assign pop.valid = count_ff != '0;
   assign pop.item  = store_ff[rd_ptr_ff];
   assign popped    = pop.valid && pop_ready;
   assign level     = count_ff;

   always_comb begin
      count_in = count_ff;
      unique case ({push.valid, popped})
         2'b10:   count_in = QCNT_W'(count_ff + QCNT_W'(1));
         2'b01:   count_in = QCNT_W'(count_ff - QCNT_W'(1));
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= QUEUE_AW'(wr_ptr_ff + QUEUE_AW'(1));
         end
         if (popped) begin
            rd_ptr_ff <= QUEUE_AW'(rd_ptr_ff + QUEUE_AW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ----- rtl/rbf_back.sv -----
module rbf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rbf_pkg::sum_xfer_type  pop,
   output logic                   pop_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rbf_pkg::rsp_type       rsp_data
);
   import rbf_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W;

   logic                                rsp_valid_ff;
   rsp_type                             rsp_data_ff, rsp_data_in;
   logic [NUM_CH-1:0][PIX_W-1:0]        quot;
   logic [NUM_CH-1:0][PROD_W-1:0]       prod;

   assign pop_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         prod[k] = PROD_W'(pop.item.sum[k]) * PROD_W'(RECIP_NINE);
         quot[k] = prod[k][RECIP_SHIFT +: PIX_W];
      end
      rsp_data_in.red_out   = quot[0];
      rsp_data_in.green_out = quot[1];
      rsp_data_in.blue_out  = quot[2];
      rsp_data_in.frame_end = pop.item.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/rgb_box_filter_3x3_unit.sv -----
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_data: one RGB pixel, raster order
// rsp      out        rsp_valid / rsp_ready  rsp_data: blurred interior pixel, frame_end
// csr      in         csr_valid / csr_ready  csr_index, csr_data: image width, height
//
// One pixel per clock sustained while req_ready stays high; the line store's one read and
// one write port per cycle set that figure. Results pass two front stages and the queue.
// Reset (synchronous) clears position counters, pipeline and queue, and sets width and
// height to 1024, not the line store. A width or height csr write restarts the image.
// req_ready drops when the queue plus the two front stages hold four items.
module rgb_box_filter_3x3_unit #(
   parameter int MAX_WIDTH  = rbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbf_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rbf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rbf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rbf_pkg::*;

   sum_xfer_type       push, pop;
   logic               pop_ready;
   logic [QCNT_W-1:0]  level;

   rbf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_level (level),
      .push        (push)
   );

   rbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (pop_ready),
      .pop       (pop),
      .level     (level)
   );

   rbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import rbf_pkg::*;

   localparam int MAX_W          = MAX_WIDTH_DEF;
   localparam int MAX_H          = MAX_HEIGHT_DEF;
   localparam int TARGET_PIXELS  = 700;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // [0] red, [1] green, [2] blue
   typedef bit [2:0][7:0] rgb_bits_type;

   class blur_scoreboard;
      rgb_bits_type          row_up1[MAX_W];
      rgb_bits_type          row_up2[MAX_W];
      rgb_bits_type          win_cols[2][3];
      int unsigned           col_pos;
      int unsigned           row_pos;
      bit [WIDTH_REG_W-1:0]  width_reg;
      bit [HEIGHT_REG_W-1:0] height_reg;
      rsp_type               blur_q[$];
      int                    failures;
      int                    pixels;
      int                    results;
      int                    frame_ends;
      int                    reg_writes;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
      endfunction

      function int unsigned clamp_size(int unsigned v, int unsigned hi);
         if (v < 3) return 3;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned eff_width();
         return clamp_size(width_reg, MAX_W);
      endfunction

      function int unsigned eff_height();
         return clamp_size(height_reg, MAX_H);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         reg_writes++;
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
         end else if (idx == CSR_IMAGE_HEIGHT) begin
            height_reg = data;
         end else begin
            return;
         end
         col_pos = 0;
         row_pos = 0;
      endfunction

      function void note_pixel(req_type px);
         int unsigned  w;
         int unsigned  h;
         int unsigned  c;
         int unsigned  r;
         int unsigned  s;
         rgb_bits_type column[3];
         rgb_bits_type avg;
         rsp_type      blur;
         w = eff_width();
         h = eff_height();
         c = col_pos;
         r = row_pos;
         if (c >= w) c = w - 1;
         if (r >= h) r = h - 1;
         column[0] = row_up2[c];
         column[1] = row_up1[c];
         column[2] = {px.blue_in, px.green_in, px.red_in};
         row_up2[c] = row_up1[c];
         row_up1[c] = column[2];
         pixels++;
         if (r >= 2 && c >= 2) begin
            for (int k = 0; k < 3; k++) begin
               s = 0;
               for (int i = 0; i < 3; i++) begin
                  s += column[i][k] + win_cols[0][i][k] + win_cols[1][i][k];
               end
               avg[k] = 8'(s / 9);
            end
            blur.red_out   = avg[0];
            blur.green_out = avg[1];
            blur.blue_out  = avg[2];
            blur.frame_end = (r == h - 1) && (c == w - 1);
            blur_q.push_back(blur);
         end
         for (int i = 0; i < 3; i++) begin
            win_cols[1][i] = win_cols[0][i];
            win_cols[0][i] = column[i];
         end
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results++;
         if (got.frame_end === 1'b1) frame_ends++;
         if (blur_q.size() == 0) begin
            $error("result with no pixel waiting: %h", got);
            failures++;
            return;
         end
         want = blur_q.pop_front();
         compare_field("red_out", want.red_out, got.red_out);
         compare_field("green_out", want.green_out, got.green_out);
         compare_field("blue_out", want.blue_out, got.blue_out);
         compare_field("frame_end", want.frame_end, got.frame_end);
      endfunction

      function int pending();
         return blur_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bit             no_gaps;
   bit             hold_rsp;
   bit             hold_used;
   int             random_pixels;
   int             stall_cycles;
   blur_scoreboard sb;

   rgb_box_filter_3x3_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_pixel(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic send_rgb(input bit [7:0] red, input bit [7:0] green, input bit [7:0] blue);
      req_type px;
      px.red_in   = red;
      px.green_in = green;
      px.blue_in  = blue;
      while (!no_gaps && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(input int count, input bit saturate, input bit counted);
      bit [7:0] ch[3];
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) begin
            if (saturate) ch[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else ch[k] = 8'($urandom);
         end
         send_rgb(ch[0], ch[1], ch[2]);
         if (counted) random_pixels++;
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned          w;
      int unsigned          h;
      int unsigned          count;
      int unsigned          pick;
      bit [CSR_DATA_W-1:0]  wdata;
      bit [CSR_DATA_W-1:0]  hdata;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_random(6, 1'b0, 1'b0);
      drain_block();

      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      write_csr(CSR_IMAGE_HEIGHT, 13'd3);
      repeat (9) send_rgb(8'hFF, 8'hFF, 8'hFF);
      repeat (9) send_rgb(8'h00, 8'h00, 8'h00);
      for (int i = 0; i < 7; i++) send_rgb(8'(i * 37), 8'(255 - i), i[0] ? 8'hFF : 8'h00);
      drain_block();

      // spare indexes must not restart the image
      write_csr(CSR_SPARE_A, 13'h1FFF);
      write_csr(CSR_SPARE_B, 13'h0AAA);
      send_rgb(8'd200, 8'd17, 8'd90);
      send_rgb(8'd1, 8'd254, 8'd128);
      drain_block();

      // undersized sizes clamp to three; stop mid-image to check the restart
      write_csr(CSR_IMAGE_WIDTH, 13'h1802);
      write_csr(CSR_IMAGE_HEIGHT, 13'd0);
      send_random(9, 1'b1, 1'b0);
      send_random(4, 1'b0, 1'b0);
      drain_block();

      // oversized sizes clamp to the maximum; first rows only
      write_csr(CSR_IMAGE_HEIGHT, 13'h1FFF);
      write_csr(CSR_IMAGE_WIDTH, 13'h07FF);
      send_random(MAX_W + 12, 1'b0, 1'b0);
      drain_block();

      while (random_pixels < TARGET_PIXELS) begin
         pick = $urandom_range(0, 9);
         w = $urandom_range(3, 12);
         if (pick == 0) w = $urandom_range(0, 2);
         else if (pick == 1) w = $urandom_range(13, 40);
         wdata = {2'($urandom), 11'(w)};
         pick = $urandom_range(0, 9);
         hdata = 13'($urandom_range(3, 8));
         if (pick == 0) hdata = 13'($urandom_range(0, 2));
         else if (pick == 1) hdata = 13'($urandom);
         case ($urandom_range(0, 5))
            0: begin
               write_csr(CSR_IMAGE_WIDTH, wdata);
               write_csr(CSR_IMAGE_HEIGHT, hdata);
            end
            1: begin
               write_csr(CSR_IMAGE_HEIGHT, hdata);
               write_csr(CSR_IMAGE_WIDTH, wdata);
            end
            2: write_csr(CSR_IMAGE_WIDTH, wdata);
            3: write_csr(CSR_IMAGE_HEIGHT, hdata);
            4: begin
               write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 13'($urandom));
               write_csr(CSR_IMAGE_WIDTH, wdata);
               write_csr(CSR_IMAGE_HEIGHT, hdata);
            end
            default: write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 13'($urandom));
         endcase
         w = sb.eff_width();
         h = sb.eff_height();
         if (h <= 16) begin
            count = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w * h - 1);
         end else begin
            count = w * $urandom_range(3, 8) + $urandom_range(0, w - 1);
         end
         no_gaps = (random_pixels >= 400) && (random_pixels < 650);
         // stall the receiver once while pixels keep coming
         if (!hold_used && random_pixels >= 150 && count >= 40) begin
            hold_rsp  = 1'b1;
            hold_used = 1'b1;
         end
         send_random(count, $urandom_range(0, 7) == 0, 1'b1);
         drain_block();
      end

      $display("run covered %0d pixels (%0d random) and %0d register writes",
               sb.pixels, random_pixels, sb.reg_writes);
      $display("checked %0d blurred results, %0d frame ends, receiver hold-off done: %0d",
               sb.results, sb.frame_ends, hold_used);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ----- rgb_box_filter_3x3_unit.f -----
rtl/rbf_pkg.sv
rtl/rbf_front.sv
rtl/rbf_queue.sv
rtl/rbf_back.sv
rtl/rgb_box_filter_3x3_unit.sv
tb/sv/testbench.sv
